/* rtl/pnn_pkg.sv */
package pnn_pkg;

  localparam int COORD_BITS_DEF       = 16;
  localparam int SUM_BITS_DEF         = 48;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int OUT_BITS             = 16;
  localparam int AXES                 = 3;
  localparam int MAG_BITS             = 30;   // normalized magnitude width
  localparam int SQ_BITS              = 62;   // sum of three squares
  localparam int ROOT_BITS            = 31;
  localparam int QDEPTH               = 2;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic               last_vertex;
  } pnn_in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } pnn_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_NORM, ST_SQ, ST_SQRT, ST_DIV, ST_DONE
  } pnn_state_t;

endpackage

/* rtl/pnn_front.sv */
// Accumulates cross products of consecutive vertices and emits the closed sum.
module pnn_front import pnn_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld,
  input  pnn_in_t                   item,
  output logic                      sum_vld,
  output logic [AXES*SUM_BITS-1:0]  sum_out
);

  localparam int PB = 2 * COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] first_r [AXES];
  logic signed [COORD_BITS-1:0] prev_r  [AXES];
  logic        [SUM_BITS-1:0]   sum_r   [AXES];
  logic                         open_r;
  logic signed [COORD_BITS-1:0] v [AXES];
  logic signed [COORD_BITS-1:0] pa [AXES];
  logic signed [PB-1:0]         c1 [AXES];
  logic signed [PB-1:0]         c2 [AXES];
  logic        [SUM_BITS-1:0]   s1 [AXES];
  logic        [SUM_BITS-1:0]   s2 [AXES];
  logic                         sum_vld_r;
  logic        [AXES*SUM_BITS-1:0] sum_out_r;

  assign v[0] = COORD_BITS'(item.vertex_x[15:0]);
  assign v[1] = COORD_BITS'(item.vertex_y[15:0]);
  assign v[2] = COORD_BITS'(item.vertex_z[15:0]);

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      pa[i] = open_r ? prev_r[i] : v[i];
    end
    // step term prev x v (zero when opening), closing term v x first
    c1[0] = PB'(pa[1] * v[2]) - PB'(pa[2] * v[1]);
    c1[1] = PB'(pa[2] * v[0]) - PB'(pa[0] * v[2]);
    c1[2] = PB'(pa[0] * v[1]) - PB'(pa[1] * v[0]);
    for (int i = 0; i < AXES; i++) begin
      s1[i] = (open_r ? sum_r[i] : '0) + (open_r ? SUM_BITS'(c1[i]) : '0);
    end
    if (open_r) begin
      c2[0] = PB'(v[1] * first_r[2]) - PB'(v[2] * first_r[1]);
      c2[1] = PB'(v[2] * first_r[0]) - PB'(v[0] * first_r[2]);
      c2[2] = PB'(v[0] * first_r[1]) - PB'(v[1] * first_r[0]);
    end else begin
      for (int i = 0; i < AXES; i++) c2[i] = '0;
    end
    for (int i = 0; i < AXES; i++) begin
      s2[i] = s1[i] + SUM_BITS'(c2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      sum_vld_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        first_r[i] <= '0;
        prev_r[i]  <= '0;
        sum_r[i]   <= '0;
      end
    end else begin
      sum_vld_r <= vld && item.last_vertex;
      if (vld) begin
        for (int i = 0; i < AXES; i++) begin
          prev_r[i] <= v[i];
          sum_r[i]  <= s1[i];
          if (!open_r) first_r[i] <= v[i];
        end
        open_r <= !item.last_vertex;
        sum_out_r <= {s2[2], s2[1], s2[0]};
      end
    end
  end

  assign sum_vld = sum_vld_r;
  assign sum_out = sum_out_r;

endmodule

/* rtl/pnn_queue.sv */
// Small FIFO of closed sums between the accumulator and the normalizer.
module pnn_queue import pnn_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic         not_empty,
  output logic         almost_full,
  output logic [W-1:0] rdata
);

  localparam int D = QDEPTH + 2;
  localparam int AW = $clog2(D);

  logic [W-1:0]  mem_r [D];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        mem_r[wp_r] <= wdata;
        wp_r <= (wp_r == AW'(D - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd) rp_r <= (rp_r == AW'(D - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  assign rdata       = mem_r[rp_r];
  assign not_empty   = cnt_r != '0;
  // two slots kept in reserve: one sum may be in flight in the accumulator
  assign almost_full = cnt_r >= (AW+1)'(D - 2);

endmodule

/* rtl/pnn_back.sv */
// Normalizes one sum to unit length with shared iterative units.
module pnn_back import pnn_pkg::*; #(
  parameter int SUM_BITS         = SUM_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [AXES*SUM_BITS-1:0] in_sum,
  output logic                     in_take,
  output logic                     res_vld,
  output pnn_out_t                 res,
  input  logic                     res_take
);

  localparam int MB = (SUM_BITS > MAG_BITS) ? SUM_BITS : MAG_BITS;
  localparam int NB = MAG_BITS + NORMAL_FRAC_BITS + 1;  // dividend width
  localparam int QB = NORMAL_FRAC_BITS + 2;
  localparam int CB = $clog2(NB + 1);

  pnn_state_t state_r, state_nxt;
  logic [MB-1:0]        mag_r [AXES];
  logic                 neg_r [AXES];
  logic [SQ_BITS-1:0]   sq_r, rem_r, bit_r;
  logic [SQ_BITS-1:0]   root_r;
  logic [1:0]           ax_r;
  logic [CB-1:0]        cnt_r;
  logic [NB-1:0]        num_r;
  logic [NB:0]          part_r;
  logic [QB-1:0]        q_r;
  logic [OUT_BITS-1:0]  res_r [AXES];
  logic                 deg_r;
  logic                 res_vld_r;

  logic [MB-1:0]        mx;
  logic [SUM_BITS-1:0]  c [AXES];
  logic [SQ_BITS-1:0]   rb;
  logic [NB:0]          trial;
  logic [ROOT_BITS-1:0] rt;
  logic [QB-1:0]        qn;

  always_comb begin
    for (int i = 0; i < AXES; i++) c[i] = in_sum[i*SUM_BITS +: SUM_BITS];
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
    rb = root_r + bit_r;
    rt = ROOT_BITS'(root_r);
    trial = {part_r[NB-1:0], num_r[NB-1]};
    qn = neg_r[ax_r] ? -q_r : q_r;
  end

  always_comb begin
    state_nxt = state_r;
    in_take   = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_vld && !res_vld_r) begin
        in_take   = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = (mx == '0) ? ST_DONE : ST_NORM;
      ST_NORM: if (mx < MB'(1 << (MAG_BITS - 1)) || mx >= MB'(1 << MAG_BITS)) begin
        state_nxt = ST_NORM;
      end else begin
        state_nxt = ST_SQ;
      end
      ST_SQ:   if (ax_r == 2'd2) state_nxt = ST_SQRT;
      ST_SQRT: if (bit_r == '0) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == '0 && ax_r == 2'd2) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      res_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_take) res_vld_r <= 1'b0;
      if (state_r == ST_DONE) res_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        for (int i = 0; i < AXES; i++) begin
          neg_r[i] <= c[i][SUM_BITS-1];
          mag_r[i] <= MB'(c[i][SUM_BITS-1] ? -c[i] : c[i]);
        end
      end
      ST_LOAD: begin
        deg_r <= (mx == '0);
        sq_r  <= '0;
        ax_r  <= '0;
        for (int i = 0; i < AXES; i++) res_r[i] <= '0;
      end
      ST_NORM: begin
        if (mx >= MB'(1 << MAG_BITS)) begin
          for (int i = 0; i < AXES; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if (mx < MB'(1 << (MAG_BITS - 1))) begin
          for (int i = 0; i < AXES; i++) mag_r[i] <= mag_r[i] << 1;
        end
      end
      ST_SQ: begin
        // one 30x30 product per cycle
        sq_r <= sq_r + SQ_BITS'(mag_r[ax_r][MAG_BITS-1:0] * mag_r[ax_r][MAG_BITS-1:0]);
        ax_r <= ax_r + 1'b1;
        rem_r  <= sq_r + SQ_BITS'(mag_r[ax_r][MAG_BITS-1:0] * mag_r[ax_r][MAG_BITS-1:0]);
        root_r <= '0;
        bit_r  <= SQ_BITS'(1) << (SQ_BITS - 2);
      end
      ST_SQRT: begin
        if (bit_r != '0) begin
          if (rem_r >= rb) begin
            rem_r  <= rem_r - rb;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          ax_r   <= '0;
          cnt_r  <= CB'(NB);
          num_r  <= NB'(mag_r[0][MAG_BITS-1:0]) << NORMAL_FRAC_BITS;
          part_r <= '0;
          q_r    <= '0;
          // the rounding term joins the dividend on the first divide cycle
          if (rt == '0) root_r <= SQ_BITS'(1);
        end
      end
      ST_DIV: begin
        if (cnt_r == NB[CB-1:0] && part_r == '0 && q_r == '0) begin
          // preload rounding: dividend = m*2^F + floor(r/2); the top bit of
          // part marks the preload as done
          num_r  <= num_r + NB'(rt >> 1);
          part_r <= {1'b1, NB'(0)};
        end else if (cnt_r != '0) begin
          if (trial[NB-1:0] >= NB'(rt) && part_r[NB] == 1'b1) begin
            part_r <= {1'b1, trial[NB-1:0] - NB'(rt)};
            q_r    <= {q_r[QB-2:0], 1'b1};
          end else begin
            part_r <= {1'b1, trial[NB-1:0]};
            q_r    <= {q_r[QB-2:0], 1'b0};
          end
          num_r <= num_r << 1;
          cnt_r <= cnt_r - 1'b1;
        end else begin
          res_r[ax_r] <= OUT_BITS'(qn);
          if (ax_r != 2'd2) begin
            ax_r   <= ax_r + 1'b1;
            cnt_r  <= CB'(NB);
            num_r  <= NB'(mag_r[ax_r + 2'd1][MAG_BITS-1:0]) << NORMAL_FRAC_BITS;
            part_r <= '0;
            q_r    <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_vld        = res_vld_r;
  assign res.normal_x   = res_r[0];
  assign res.normal_y   = res_r[1];
  assign res.normal_z   = res_r[2];
  assign res.degenerate = deg_r;

endmodule

/* rtl/polygon_normal_newell.sv */
// A vertex is added into the running sum as it is accepted. A closing item's normal then
// goes through the normalizing shifts (0 to 29 of them), the sum of squares, the
// bit-serial square root and the shared restoring divider, one axis after another; a
// zero sum skips these steps and is flagged degenerate.
// Throughput: one vertex per cycle while the sum queue has room; the back end takes the
// next sum only when it is idle and its last normal has been popped. Reset (synchronous,
// rst_n low) clears the open polygon, the sums, the queue and any pending result.
module polygon_normal_newell import pnn_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int SUM_BITS         = SUM_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  pnn_in_t  in_item,
  output logic     empty,
  input  logic     pop,
  output pnn_out_t out_item
);

  logic                     acc;
  logic                     sum_vld;
  logic [AXES*SUM_BITS-1:0] sum;
  logic                     q_ne, q_af, q_rd;
  logic [AXES*SUM_BITS-1:0] q_data;
  logic                     res_vld;

  // The front end takes vertices while the queue of closed sums has room.
  assign full = q_af;
  assign acc  = push && !full;

  pnn_front #(.COORD_BITS(COORD_BITS), .SUM_BITS(SUM_BITS)) u_front (
    .clk, .rst_n, .vld(acc), .item(in_item), .sum_vld, .sum_out(sum)
  );

  pnn_queue #(.W(AXES*SUM_BITS)) u_queue (
    .clk, .rst_n, .wr(sum_vld), .wdata(sum), .rd(q_rd),
    .not_empty(q_ne), .almost_full(q_af), .rdata(q_data)
  );

  // The back end holds its finished normal in an output register until popped.
  pnn_back #(.SUM_BITS(SUM_BITS), .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
    .clk, .rst_n, .in_vld(q_ne), .in_sum(q_data), .in_take(q_rd),
    .res_vld, .res(out_item), .res_take(pop && !empty)
  );

  assign empty = !res_vld;

endmodule

/* tb/tb_polygon_normal_newell.sv */
`timescale 1ns / 100ps

module tb_polygon_normal_newell;
  import pnn_pkg::*;

  // Sizes of the block as instantiated; the checker's model is built on these.
  localparam int SB = SUM_BITS_DEF;
  localparam int FB = NORMAL_FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk;
  logic     rst_n;
  logic     push;
  logic     full;
  pnn_in_t  in_item;
  logic     empty;
  logic     pop;
  pnn_out_t out_item;

  polygon_normal_newell uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // The checker's own copy of the polygon state.
  logic signed [15:0] first_vtx [3];
  logic signed [15:0] prev_vtx [3];
  logic [SB-1:0]      normal_sum [3];
  logic               poly_open;

  pnn_out_t normal_queue[$];

  int send_idle_pct;    // percent of cycles in which the sender holds back
  int recv_stall_pct;   // percent of cycles in which the receiver holds back
  bit recv_hold;        // long hold-off of the receiver
  int mismatches;
  int items_sent;
  int normals_seen;
  int degenerate_seen;
  int quiet_cycles;

  // Adds a x b into the running sum, wrapping at the sum width.
  function automatic void add_cross(input logic signed [15:0] a [3],
                                    input logic signed [15:0] b [3]);
    longint c [3];
    c[0] = longint'(a[1]) * b[2] - longint'(a[2]) * b[1];
    c[1] = longint'(a[2]) * b[0] - longint'(a[0]) * b[2];
    c[2] = longint'(a[0]) * b[1] - longint'(a[1]) * b[0];
    for (int i = 0; i < 3; i++) normal_sum[i] = normal_sum[i] + c[i][SB-1:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Updates the polygon state with one vertex and queues the normal on a
  // closing vertex.
  function automatic void predict_vertex(input pnn_in_t v);
    logic signed [15:0] p [3];
    logic [63:0] mag [3];
    logic        neg [3];
    logic [63:0] mx, sq, root, q;
    pnn_out_t    n;
    p[0] = v.vertex_x; p[1] = v.vertex_y; p[2] = v.vertex_z;
    if (!poly_open) begin
      for (int i = 0; i < 3; i++) begin
        first_vtx[i] = p[i];
        prev_vtx[i] = p[i];
        normal_sum[i] = '0;
      end
      poly_open = 1'b1;
    end else begin
      add_cross(prev_vtx, p);
      prev_vtx = p;
    end
    if (!v.last_vertex) return;
    add_cross(prev_vtx, first_vtx);
    poly_open = 1'b0;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = normal_sum[i][SB-1];
      mag[i] = neg[i] ? 64'((-normal_sum[i]) & {SB{1'b1}}) : 64'(normal_sum[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    n = '0;
    if (mx == 0) begin
      n.degenerate = 1'b1;
    end else begin
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
      root = int_sqrt(sq);
      if (root == 0) root = 1;
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << FB) + (root >> 1)) / root;
        if (neg[i]) q = -q;
        case (i)
          0: n.normal_x = q[15:0];
          1: n.normal_y = q[15:0];
          default: n.normal_z = q[15:0];
        endcase
      end
    end
    normal_queue.push_back(n);
  endfunction

  // Offers one vertex, honoring the sender's idle rate, and waits until the
  // block takes it. push stays high between back-to-back items.
  task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input logic last);
    pnn_in_t v;
    v.vertex_x = x; v.vertex_y = y; v.vertex_z = z; v.last_vertex = last;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_vertex(v);
    items_sent++;
  endtask

  function automatic logic signed [15:0] rand_coord(input int range_sel);
    case (range_sel)
      0: return 16'($urandom_range(0, 40)) - 16'sd20;
      1: return 16'($urandom_range(0, 2000)) - 16'sd1000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_polygon(input int nverts, input int range_sel);
    for (int k = 0; k < nverts; k++)
      send_vertex(rand_coord(range_sel), rand_coord(range_sel), rand_coord(range_sel),
                  k == nverts - 1);
  endtask

  // Stops offering vertices and waits until every queued normal has come back.
  task automatic drain;
    push <= 1'b0;
    while (normal_queue.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Receiver: pops at a random stall rate, unless a long hold-off is on.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checks each accepted normal against the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      normals_seen++;
      if (out_item.degenerate) degenerate_seen++;
      if (normal_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected normal %p", out_item);
      end else begin
        if (out_item !== normal_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal %0d: expected %p, got %p", normals_seen,
                     normal_queue[0], out_item);
        end
        void'(normal_queue.pop_front());
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress, %0d normals outstanding", normal_queue.size());
        $display("polygon_normal_newell: mismatch");
        $finish;
      end
    end
  end

  // Directed cases: single vertex, flat and zero-area polygons, extremes,
  // a long polygon of large coordinates, and axis-aligned normals.
  task automatic test_directed;
    send_vertex(16'sd5, -16'sd7, 16'sd9, 1'b1);                  // single vertex
    send_vertex(16'sd0, 16'sd0, 16'sd0, 1'b0);                   // unit triangle in xy
    send_vertex(16'sd1, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1, 16'sd0, 1'b1);
    send_vertex(16'sd0, 16'sd0, 16'sd0, 1'b0);                   // unit triangle in yz, normal along -x
    send_vertex(16'sd0, 16'sd0, 16'sd1, 1'b0);
    send_vertex(16'sd0, 16'sd1, 16'sd0, 1'b1);
    send_vertex(16'sd3, 16'sd3, 16'sd3, 1'b0);                   // collinear: zero sum
    send_vertex(16'sd6, 16'sd6, 16'sd6, 1'b1);
    send_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);          // coordinate extremes
    send_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0);
    send_vertex(16'sh8000, 16'sh8000, 16'sh7fff, 1'b1);
    send_vertex(-16'sd1, -16'sd1, -16'sd1, 1'b0);                // all ones
    send_vertex(16'sd1, -16'sd2, 16'sd3, 1'b1);
    // Ten large vertices in one polygon; the sum stays well within its width.
    for (int k = 0; k < 10; k++)
      send_vertex(k[0] ? 16'sh7fff : 16'sh8000, k[1] ? 16'sh8000 : 16'sh7fff,
                  16'(k * 3000), k == 9);
    drain();
  endtask

  // Random polygons, mostly small sizes; a few long ones and a little noise
  // in the form of single-vertex polygons.
  task automatic test_random(input int nitems);
    int target;
    target = items_sent + nitems;
    while (items_sent < target) begin
      if ($urandom_range(9) == 0) send_polygon(1, $urandom_range(2));
      else if ($urandom_range(19) == 0) send_polygon($urandom_range(8, 20), $urandom_range(2));
      else send_polygon($urandom_range(2, 6), $urandom_range(2));
    end
    drain();
  endtask

  // The receiver stops for a long stretch while vertices keep coming, so the
  // sum queue fills and the block must stall its input.
  task automatic test_backpressure;
    int hold_cycles;
    recv_hold = 1'b1;
    fork
      begin
        hold_cycles = 0;
        while (hold_cycles < 3000) begin
          @(posedge clk);
          hold_cycles++;
        end
        recv_hold = 1'b0;
      end
      for (int k = 0; k < 12; k++) send_polygon(3, 1);
    join
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_item = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b0;
    mismatches = 0;
    items_sent = 0;
    normals_seen = 0;
    degenerate_seen = 0;
    quiet_cycles = 0;
    poly_open = 1'b0;
    for (int i = 0; i < 3; i++) begin
      first_vtx[i] = '0;
      prev_vtx[i] = '0;
      normal_sum[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(225);
    send_idle_pct = 63;
    test_random(225);
    send_idle_pct = 0;
    recv_stall_pct = 63;
    test_random(225);
    send_idle_pct = 6;
    recv_stall_pct = 6;
    test_random(225);
    test_backpressure();
    repeat (300) @(posedge clk);

    $display("Sent %0d vertices and checked %0d normals, %0d of them degenerate,",
             items_sent, normals_seen, degenerate_seen);
    $display("over idle, stalled and back-pressured phases; %0d mismatches.", mismatches);
    if (mismatches == 0 && normal_queue.size() == 0) begin
      $display("polygon_normal_newell: match");
    end else begin
      $display("polygon_normal_newell: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pnn_pkg.sv
rtl/pnn_front.sv
rtl/pnn_queue.sv
rtl/pnn_back.sv
rtl/polygon_normal_newell.sv
tb/tb_polygon_normal_newell.sv
